/* rtl/core/hbp_pkg.sv */
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared constants and types of the Huffman bit packer: field widths, table
// geometry, operation codes, status codes and the lookup record.
// ----------------------------------------------------------------------------
package hbp_pkg;

    localparam int CODE_W       = 32;
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_LIMIT   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int LEN_W        = 6;
    localparam int NUM_ENTRIES  = 257;
    localparam int END_ENTRY    = 256;
    localparam int ADDR_W       = $clog2(NUM_ENTRIES);
    localparam int ENTRY_W      = CODE_W + LEN_W;
    localparam int BYTE_W       = 8;
    localparam int BUF_W        = CODE_W + BYTE_W;
    localparam int CNT_W        = $clog2(BUF_W);
    localparam int FUNC_W       = 2;
    localparam int S_TDATA_W    = 48;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END    = 2'd2;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NOCODE = 1'b1;

    // Result of a table lookup, handed from the table stage to the packer
    typedef struct packed {
        logic              is_end;
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } lookup_t;

endpackage

/* rtl/core/hbp_table.sv */
// ----------------------------------------------------------------------------
// hbp_table
// Code table: a synchronous memory of codes and lengths with a valid bit per
// entry. Loads write the memory; encode and end transactions read it and the
// read result is held in a one-entry lookup stage until the packer takes it.
// ----------------------------------------------------------------------------
module hbp_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hbp_pkg::FUNC_W-1:0]   in_func,
    input  logic [hbp_pkg::ADDR_W-1:0]   in_symbol,
    input  logic [hbp_pkg::CODE_W-1:0]   in_code,
    input  logic [hbp_pkg::LEN_W-1:0]    in_len,
    output logic                         lk_valid,
    output hbp_pkg::lookup_t             lk,
    input  logic                         lk_ready
);
    import hbp_pkg::*;

    logic [ENTRY_W-1:0]     code_mem [NUM_ENTRIES];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_end_reg, s1_end_next;
    logic                   s1_hit_reg, s1_hit_next;

    logic                   accept;
    logic                   in_range;
    logic                   is_lookup;
    logic                   is_end;
    logic                   wr_en;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [LEN_W-1:0]       len_clamped;
    logic [CODE_W:0]        mask_wide;
    logic [CODE_W-1:0]      code_masked;

    assign in_ready  = !s1_valid_reg || lk_ready;
    assign accept    = in_valid && in_ready;
    assign in_range  = in_symbol <= ADDR_W'(END_ENTRY);
    assign is_end    = in_func == FUNC_END;
    assign is_lookup = (in_func == FUNC_ENCODE) || is_end;
    assign wr_en     = accept && (in_func == FUNC_LOAD) && in_range;
    assign rd_en     = accept && is_lookup;
    assign rd_addr   = (is_end || !in_range) ? ADDR_W'(END_ENTRY) : in_symbol;

    // Clamp the length and drop code bits above it
    assign len_clamped = (in_len > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT) : in_len;
    assign mask_wide   = ((CODE_W + 1)'(1) << len_clamped) - (CODE_W + 1)'(1);
    assign code_masked = in_code & mask_wide[CODE_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            code_mem[in_symbol] <= {len_clamped, code_masked};
        end
        if (rd_en) begin
            rd_data_reg <= code_mem[rd_addr];
        end
    end

    always_comb begin
        valid_next    = valid_reg;
        s1_end_next   = s1_end_reg;
        s1_hit_next   = s1_hit_reg;
        s1_valid_next = s1_valid_reg && !lk_ready;
        if (wr_en) begin
            valid_next[in_symbol] = 1'b1;
        end
        if (accept) begin
            s1_valid_next = is_lookup;
            s1_end_next   = is_end;
            if (is_end) begin
                s1_hit_next = valid_reg[END_ENTRY];
            end else begin
                s1_hit_next = (in_symbol < ADDR_W'(END_ENTRY)) && valid_reg[in_symbol];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_end_reg   <= 1'b0;
            s1_hit_reg   <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            s1_valid_reg <= s1_valid_next;
            s1_end_reg   <= s1_end_next;
            s1_hit_reg   <= s1_hit_next;
        end
    end

    assign lk_valid = s1_valid_reg;
    assign lk       = '{is_end: s1_end_reg, hit: s1_hit_reg,
                        len: rd_data_reg[ENTRY_W-1:CODE_W],
                        code: rd_data_reg[CODE_W-1:0]};

endmodule

/* rtl/core/hbp_packer.sv */
// ----------------------------------------------------------------------------
// hbp_packer
// Bit accumulator and byte emitter. Pending bits sit left aligned in a wide
// buffer; a lookup merges its code behind them and full bytes leave from the
// top, one per cycle while the output is not stalled, through the output register.
// ----------------------------------------------------------------------------
module hbp_packer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         lk_valid,
    input  hbp_pkg::lookup_t             lk,
    output logic                         lk_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hbp_pkg::BYTE_W-1:0]   out_byte,
    output logic                         out_last,
    output logic                         out_status
);
    import hbp_pkg::*;

    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              flush_reg, flush_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_status_reg, out_status_next;

    logic              out_free;
    logic              cnt_ge8;
    logic              pending;
    logic              take;
    logic              merge;
    logic              err;
    logic              emit;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  shamt;
    logic [BUF_W-1:0]  code_placed;
    logic [CNT_W-1:0]  cnt_after;

    assign out_free = !out_valid_reg || out_ready;
    assign cnt_ge8  = cnt_reg >= CNT_W'(BYTE_W);
    assign pending  = cnt_ge8 || (flush_reg && (cnt_reg != '0));
    // A hit only merges; an error result needs the output register
    assign lk_ready = !pending && (lk.hit || out_free);
    assign take     = lk_valid && lk_ready;
    assign merge    = take && lk.hit;
    assign err      = take && !lk.hit;
    assign emit     = pending && out_free;

    assign total       = cnt_reg + CNT_W'(lk.len);
    assign shamt       = CNT_W'(BUF_W) - total;
    assign code_placed = BUF_W'(lk.code) << shamt;
    assign cnt_after   = cnt_reg - CNT_W'(BYTE_W);

    always_comb begin
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        flush_next      = flush_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        if (emit) begin
            buf_next        = buf_reg << BYTE_W;
            out_valid_next  = 1'b1;
            out_byte_next   = buf_reg[BUF_W-1 -: BYTE_W];
            out_status_next = STATUS_OK;
            if (cnt_ge8) begin
                cnt_next      = cnt_after;
                flush_next    = flush_reg && (cnt_after != '0);
                out_last_next = !((cnt_after >= CNT_W'(BYTE_W)) ||
                                  (flush_reg && (cnt_after != '0)));
            end else begin
                // padded tail byte: zeros already sit below the pending bits
                cnt_next      = '0;
                flush_next    = 1'b0;
                out_last_next = 1'b1;
            end
        end else if (merge) begin
            buf_next   = buf_reg | code_placed;
            cnt_next   = total;
            flush_next = lk.is_end && (total != '0);
        end else if (err) begin
            out_valid_next  = 1'b1;
            out_byte_next   = '0;
            out_last_next   = 1'b1;
            out_status_next = STATUS_NOCODE;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg       <= '0;
            cnt_reg       <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

endmodule

/* rtl/core/huffman_bit_packer.sv */
// Order: an encode or end transaction passes the table read register, the merge into
//   the bit buffer and then the output register to m_tdata; an error result skips the merge.
// Flow: a load only writes the table; an encode or end merges once no byte is pending,
//   and the packer emits every full byte (and a flush tail) before it takes the next lookup.
// Reset: synchronous active-low aresetn clears the entry valid bits, the bit
//   buffer and the output valid flag; table contents are kept but read as unloaded.
// ----------------------------------------------------------------------------
// huffman_bit_packer
// Huffman encoder output stage: code table lookup and MSB-first bit packing
// into bytes, with end-of-stream code and zero-padded flush.
// ----------------------------------------------------------------------------
module huffman_bit_packer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [8:0] symbol, [40:9] code_value, [46:41] code_length, [47] zero
    input  logic [hbp_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] func
    input  logic [hbp_pkg::FUNC_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] out_byte
    output logic [hbp_pkg::BYTE_W-1:0]      m_tdata,
    output logic                            m_tlast,
    // [0] status
    output logic [0:0]                      m_tuser
);
    import hbp_pkg::*;

    localparam int SYM_LSB  = 0;
    localparam int CODE_LSB = SYM_LSB + ADDR_W;
    localparam int LEN_LSB  = CODE_LSB + CODE_W;

    logic    lk_valid;
    logic    lk_ready;
    lookup_t lk;

    hbp_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_symbol (s_tdata[SYM_LSB +: ADDR_W]),
        .in_code   (s_tdata[CODE_LSB +: CODE_W]),
        .in_len    (s_tdata[LEN_LSB +: LEN_W]),
        .lk_valid  (lk_valid),
        .lk        (lk),
        .lk_ready  (lk_ready)
    );

    hbp_packer u_packer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lk_valid   (lk_valid),
        .lk         (lk),
        .lk_ready   (lk_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_status (m_tuser[0])
    );

endmodule

/* rtl/core/hbp_checker.sv */
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks of the Huffman bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module hbp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [hbp_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [hbp_pkg::FUNC_W-1:0]      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hbp_pkg::BYTE_W-1:0]      m_tdata,
    input logic                            m_tlast,
    input logic [0:0]                      m_tuser
);
    import hbp_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // Missing-code result carries a zero byte and closes the transaction
    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == STATUS_NOCODE) |-> (m_tdata == '0) && m_tlast)
        else $error("malformed error result");

    // Nothing leaves during or right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Stalled input transaction holds until accepted
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input changed while stalled");

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: Huffman bit packer testbench
// Drives load, encode, end and no-operation transactions with random gaps on both sides.
// Predicts every packed byte and error result with a local code table and bit
// accumulator, and compares each result with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
    import hbp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 37;

    // func value with no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [8:0]        symbol;
        logic [CODE_W-1:0] value;
        logic [LEN_W-1:0]  length;
        bit                hold;      // wait for all results before sending
    } packer_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              status;
    } packed_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]    s_tuser  = FUNC_LOAD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic [0:0]           m_tuser;

    packer_item_t   pending_items[$];
    packed_result_t expected_bytes[$];

    // Predicted packer state
    logic [CODE_W-1:0] model_code   [0:NUM_ENTRIES-1];
    logic [LEN_W-1:0]  model_len    [0:NUM_ENTRIES-1];
    bit                model_loaded [0:NUM_ENTRIES-1];
    logic [7:0]        model_acc  = '0;
    int                model_held = 0;

    int  items_sent = 0;
    int  mismatches = 0;
    int  cycles     = 0;
    logic calm_phase;

    // no idling on either side in the middle of the run
    assign calm_phase = (items_sent >= 70) && (items_sent < 110);

    huffman_bit_packer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic void push_result(logic [7:0] data, logic status);
        packed_result_t r;
        r.data   = data;
        r.last   = 1'b0;
        r.status = status;
        expected_bytes.push_back(r);
    endfunction

    function automatic void shift_code_bits(int idx);
        for (int i = int'(model_len[idx]) - 1; i >= 0; i--) begin
            model_acc = {model_acc[6:0], model_code[idx][i]};
            model_held++;
            if (model_held == BYTE_W) begin
                push_result(model_acc, STATUS_OK);
                model_acc  = '0;
                model_held = 0;
            end
        end
    endfunction

    // Work out the results of one accepted transaction
    function automatic void pack_expected_bytes(logic [FUNC_W-1:0] func, logic [8:0] symbol,
                                                logic [CODE_W-1:0] value,
                                                logic [LEN_W-1:0] length);
        int             prev_count;
        int             len;
        packed_result_t r;
        prev_count = expected_bytes.size();
        len        = int'(length);
        if (func == FUNC_LOAD) begin
            if (symbol < NUM_ENTRIES) begin
                if (len > CODE_LIMIT)
                    len = CODE_LIMIT;
                if (len < CODE_W)
                    value = value & CODE_W'((64'd1 << len) - 64'd1);
                model_code[symbol]   = value;
                model_len[symbol]    = LEN_W'(len);
                model_loaded[symbol] = 1'b1;
            end
        end else if (func == FUNC_ENCODE) begin
            if (symbol >= END_ENTRY || !model_loaded[symbol])
                push_result('0, STATUS_NOCODE);
            else
                shift_code_bits(symbol);
        end else if (func == FUNC_END) begin
            if (!model_loaded[END_ENTRY]) begin
                push_result('0, STATUS_NOCODE);
            end else begin
                shift_code_bits(END_ENTRY);
                if (model_held != 0)
                    push_result(model_acc << (BYTE_W - model_held), STATUS_OK);
                model_acc  = '0;
                model_held = 0;
            end
        end
        if (expected_bytes.size() > prev_count) begin
            r = expected_bytes.pop_back();
            r.last = 1'b1;
            expected_bytes.push_back(r);
        end
    endfunction

    // Driver: hold a transaction until accepted, then fetch the next one
    always @(posedge aclk) begin : driver
        packer_item_t nxt;
        bit           go;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pack_expected_bytes(s_tuser, s_tdata[8:0], s_tdata[40:9], s_tdata[46:41]);
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                go = pending_items.size() != 0;
                if (go && pending_items[0].hold && expected_bytes.size() != 0)
                    go = 1'b0;
                if (go && !calm_phase && $urandom_range(0, 99) < IDLE_PCT)
                    go = 1'b0;
                if (go) begin
                    nxt = pending_items.pop_front();
                    s_tdata  <= {1'b0, nxt.length, nxt.value, nxt.symbol};
                    s_tuser  <= nxt.func;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : monitor
        packed_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: byte %02h last %0d status %0d",
                                 m_tdata, m_tlast, m_tuser[0]);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last ||
                        m_tuser[0] !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected byte %02h last %0d status %0d,",
                                      " got byte %02h last %0d status %0d"},
                                     want.data, want.last, want.status,
                                     m_tdata, m_tlast, m_tuser[0]);
                    end
                end
            end
            m_tready <= calm_phase || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** huffman_bit_packer: FAILED **");
            $finish;
        end
    end

    function automatic void add_item(logic [FUNC_W-1:0] func, int symbol,
                                     logic [CODE_W-1:0] value, int length, bit hold = 1'b0);
        packer_item_t it;
        it.func   = func;
        it.symbol = 9'(symbol);
        it.value  = value;
        it.length = LEN_W'(length);
        it.hold   = hold;
        pending_items.push_back(it);
    endfunction

    function automatic int pick_code_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        else if (r < 75)
            return $urandom_range(1, 12);
        else if (r < 92)
            return $urandom_range(13, 32);
        return $urandom_range(33, 63);
    endfunction

    initial begin
        int loaded_syms[$];
        int r;
        int sym;

        // Directed: errors before any load, ignored items, extremes of the fields
        add_item(FUNC_ENCODE, 5, 32'h0, 0);
        add_item(FUNC_END, 0, 32'h0, 0);
        add_item(FUNC_NONE, 511, 32'hFFFF_FFFF, 63);
        add_item(FUNC_LOAD, 300, 32'h0000_0123, 5);
        add_item(FUNC_ENCODE, 300, 32'h0, 0);
        add_item(FUNC_ENCODE, 511, 32'h0, 0);
        add_item(FUNC_LOAD, 0, 32'hFFFF_FFFF, 0);
        add_item(FUNC_ENCODE, 0, 32'h0, 0);
        add_item(FUNC_LOAD, 255, 32'hFFFF_FFFF, 32);
        add_item(FUNC_LOAD, 1, 32'h0000_00A5, 8);
        add_item(FUNC_LOAD, 2, 32'hFFFF_FFFF, 63);
        add_item(FUNC_LOAD, 3, 32'hFFFF_FFFD, 3);
        add_item(FUNC_LOAD, 4, 32'h0000_006B, 7);
        add_item(FUNC_ENCODE, 1, 32'h0, 0);
        add_item(FUNC_ENCODE, 255, 32'h0, 0);
        add_item(FUNC_ENCODE, 3, 32'h0, 0);
        add_item(FUNC_ENCODE, 2, 32'h0, 0);
        add_item(FUNC_ENCODE, 256, 32'h0, 0);
        add_item(FUNC_LOAD, 256, 32'h0, 0);
        add_item(FUNC_END, 0, 32'h0, 0);
        add_item(FUNC_END, 0, 32'h0, 0);
        add_item(FUNC_LOAD, 256, 32'h8000_0001, 32);
        add_item(FUNC_ENCODE, 4, 32'h0, 0);
        add_item(FUNC_END, 0, 32'h0, 0);

        // Random: load a fresh code set, then mostly encode loaded bytes
        add_item(FUNC_LOAD, 256, $urandom, pick_code_len(), 1'b1);
        for (int i = 0; i < 20; i++) begin
            sym = $urandom_range(0, 255);
            add_item(FUNC_LOAD, sym, $urandom, pick_code_len());
            loaded_syms.push_back(sym);
        end
        loaded_syms.push_back(1);
        loaded_syms.push_back(255);
        for (int i = 0; i < 115; i++) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
                add_item(FUNC_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                         $urandom, $urandom_range(0, 63), i == 60);
            end else if (r < 78) begin
                add_item(FUNC_END, $urandom_range(0, 511), $urandom, $urandom_range(0, 63));
            end else if (r < 84) begin
                sym = $urandom_range(0, 256);
                add_item(FUNC_LOAD, sym, $urandom, pick_code_len());
                if (sym < END_ENTRY)
                    loaded_syms.push_back(sym);
            end else if (r < 90) begin
                add_item(FUNC_ENCODE, $urandom_range(0, 511), $urandom, 0);
            end else if (r < 95) begin
                add_item(FUNC_LOAD, $urandom_range(257, 511), $urandom, $urandom_range(0, 63));
            end else begin
                add_item(FUNC_NONE, $urandom_range(0, 511), $urandom, $urandom_range(0, 63));
            end
        end
        add_item(FUNC_END, 0, 32'h0, 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("** huffman_bit_packer: PASSED **");
        end else begin
            $display("** huffman_bit_packer: FAILED **");
        end
        $finish;
    end

endmodule
